// File: rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants for the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // Fixed field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned CUR_W    = 10;
  localparam int unsigned FADDR_W  = 11;
  localparam int unsigned FBYTE_W  = 8;
  localparam int unsigned FB_W     = 12;
  localparam int unsigned IDX_W    = 24;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  // Control characters
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;

  // Register reset values
  localparam logic [FB_W-1:0]    RST_FB_WIDTH  = 12'd320;
  localparam logic [FB_W-1:0]    RST_FB_HEIGHT = 12'd480;
  localparam logic [CUR_W-1:0]   RST_TEXT_COLS = 10'd53;
  localparam logic [CUR_W-1:0]   RST_TEXT_ROWS = 10'd48;
  localparam logic [COLOR_W-1:0] RST_FG_COLOR  = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] RST_BG_COLOR  = 32'h0000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_FONT   = 2'd3
  } kind_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_PIXEL  = 2'd0,
    EV_SCROLL = 2'd1,
    EV_CLEAR  = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_FB_WIDTH  = 3'd1,
    CFG_FB_HEIGHT = 3'd2,
    CFG_TEXT_COLS = 3'd3,
    CFG_TEXT_ROWS = 3'd4,
    CFG_FG_COLOR  = 3'd5,
    CFG_BG_COLOR  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CHAR = 2'd1,
    ST_EVT  = 2'd2
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RS_IDLE = 2'd0,
    RS_BASE = 2'd1,
    RS_RUN  = 2'd2
  } raster_phase_e;

  // Raster walker status towards the controller
  typedef struct packed {
    logic             busy;
    logic             valid;
    logic             last;
    logic             oob;
    logic [2:0]       bit_sel;
    logic [IDX_W-1:0] pix_index;
  } raster_pix_t;

endpackage

// File: rtl/text_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Pixel items of a character pass the walker base step, the glyph store read
//   and the output register, one pixel per cycle (set by the single glyph store
//   read port) while the output is not stalled, then a scroll item if one follows.
// Cursor moves, font writes and non-scrolling control characters emit no item;
//   clear and a scrolling control character emit one event item.
// Reset clears cursor and control state and loads register defaults; the glyph
//   store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
  parameter int unsigned GLYPH_W     = 6,
  parameter int unsigned GLYPH_H     = 10,
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // char_code[7:0], cursor_col[17:8], cursor_row[27:18], font_addr[38:28],
  // font_byte[46:39], zero pad[47]
  input  logic [tcgr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind[1:0]
  input  logic [tcgr_pkg::KIND_W-1:0]        s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_index[23:0], color[55:24]
  output logic [tcgr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // event_res[1:0]
  output logic [tcgr_pkg::EVENT_W-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned WH          = GLYPH_W * GLYPH_H;
  localparam int unsigned STORE_BYTES = (GLYPH_COUNT * WH + 7) / 8;
  localparam int unsigned ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned CUR_W       = tcgr_pkg::CUR_W;
  localparam int unsigned FB_W        = tcgr_pkg::FB_W;
  localparam int unsigned IDX_W       = tcgr_pkg::IDX_W;
  localparam int unsigned COLOR_W     = tcgr_pkg::COLOR_W;

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  tcgr_pkg::kind_e                in_kind;
  logic [tcgr_pkg::CHAR_W-1:0]    in_char;
  logic [CUR_W-1:0]               in_col, in_row;
  logic [tcgr_pkg::FADDR_W-1:0]   in_faddr;
  logic [tcgr_pkg::FBYTE_W-1:0]   in_fbyte;
  logic                           in_accept;

  assign in_kind   = tcgr_pkg::kind_e'(s_axis_tuser);
  assign in_char   = s_axis_tdata[7:0];
  assign in_col    = s_axis_tdata[17:8];
  assign in_row    = s_axis_tdata[27:18];
  assign in_faddr  = s_axis_tdata[38:28];
  assign in_fbyte  = s_axis_tdata[46:39];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               enable_q;
  logic [FB_W-1:0]    fb_width_q, fb_height_q;
  logic [CUR_W-1:0]   text_cols_q, text_rows_q;
  logic [COLOR_W-1:0] fg_color_q, bg_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      fb_width_q  <= tcgr_pkg::RST_FB_WIDTH;
      fb_height_q <= tcgr_pkg::RST_FB_HEIGHT;
      text_cols_q <= tcgr_pkg::RST_TEXT_COLS;
      text_rows_q <= tcgr_pkg::RST_TEXT_ROWS;
      fg_color_q  <= tcgr_pkg::RST_FG_COLOR;
      bg_color_q  <= tcgr_pkg::RST_BG_COLOR;
    end else if (cfg_we_i) begin
      case (tcgr_pkg::cfg_idx_e'(cfg_idx_i))
        tcgr_pkg::CFG_ENABLE:    enable_q    <= cfg_wdata_i[0];
        tcgr_pkg::CFG_FB_WIDTH:  fb_width_q  <= cfg_wdata_i[FB_W-1:0];
        tcgr_pkg::CFG_FB_HEIGHT: fb_height_q <= cfg_wdata_i[FB_W-1:0];
        tcgr_pkg::CFG_TEXT_COLS: text_cols_q <= cfg_wdata_i[CUR_W-1:0];
        tcgr_pkg::CFG_TEXT_ROWS: text_rows_q <= cfg_wdata_i[CUR_W-1:0];
        tcgr_pkg::CFG_FG_COLOR:  fg_color_q  <= cfg_wdata_i;
        tcgr_pkg::CFG_BG_COLOR:  bg_color_q  <= cfg_wdata_i;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  tcgr_pkg::ctrl_state_e state_q, state_d;
  logic [CUR_W-1:0]      cur_col_q, cur_col_d;
  logic [CUR_W-1:0]      cur_row_q, cur_row_d;
  logic                  scroll_q, scroll_d;     // scroll item follows the pixels
  tcgr_pkg::event_e      evt_q, evt_d;           // event held for ST_EVT
  logic                  raster_start;
  logic                  font_we;

  // Pixel pipeline: read issue -> stage B (memory data) -> output register
  tcgr_pkg::raster_pix_t pix;
  logic [ADDR_W-1:0]     rd_addr;
  logic [7:0]            rd_data;
  logic                  out_free, issue, b_to_out, evt_to_out;
  logic                  b_valid_q, b_valid_d;
  logic                  b_oob_q, b_last_q;
  logic [2:0]            b_sel_q;
  logic [IDX_W-1:0]      b_idx_q;

  logic                  o_valid_q, o_valid_d;
  tcgr_pkg::event_e      o_ev_q;
  logic [IDX_W-1:0]      o_idx_q;
  logic [COLOR_W-1:0]    o_color_q;
  logic                  o_last_q;

  logic                  b_bit;
  logic [IDX_W-1:0]      extent;

  assign out_free   = !o_valid_q || m_axis_tready;
  assign issue      = pix.valid && (!b_valid_q || out_free);
  assign b_to_out   = b_valid_q && out_free;
  // an event leaves only once every pixel ahead of it has gone
  assign evt_to_out = (state_q == tcgr_pkg::ST_EVT) && !b_valid_q && out_free;

  assign s_axis_tready = (state_q == tcgr_pkg::ST_IDLE);

  // Next cursor, next state and side effects of an accepted item
  always_comb begin
    logic [CUR_W-1:0] col_a, row_a, row_w;
    logic             wrap_chk, is_print, scroll;
    state_d      = state_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    scroll_d     = scroll_q;
    evt_d        = evt_q;
    raster_start = 1'b0;
    font_we      = 1'b0;
    col_a        = cur_col_q;
    row_a        = cur_row_q;
    row_w        = cur_row_q;
    wrap_chk     = 1'b0;
    is_print     = 1'b0;
    scroll       = 1'b0;

    if (in_kind == tcgr_pkg::KIND_CHAR && enable_q) begin
      wrap_chk = 1'b1;
      if (in_char == tcgr_pkg::CHAR_CR) begin
        col_a = '0;
      end else if (in_char == tcgr_pkg::CHAR_LF) begin
        col_a = '0;
        row_a = cur_row_q + CUR_W'(1);
      end else begin
        col_a    = cur_col_q + CUR_W'(1);
        is_print = 1'b1;
      end
    end
    // Wrap at the right edge, then scroll at the bottom
    if (col_a >= text_cols_q) begin
      row_w = row_a + CUR_W'(1);
      col_a = '0;
    end else begin
      row_w = row_a;
    end
    scroll = wrap_chk && (row_w >= text_rows_q);

    case (state_q)
      tcgr_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_kind)
            tcgr_pkg::KIND_CHAR: begin
              if (wrap_chk) begin
                cur_col_d = col_a;
                cur_row_d = scroll ? (row_w - CUR_W'(1)) : row_w;
                scroll_d  = scroll;
                evt_d     = tcgr_pkg::EV_SCROLL;
                if (is_print) begin
                  raster_start = 1'b1;
                  state_d      = tcgr_pkg::ST_CHAR;
                end else if (scroll) begin
                  state_d = tcgr_pkg::ST_EVT;
                end
              end
            end
            tcgr_pkg::KIND_CURSOR: begin
              cur_col_d = in_col;
              cur_row_d = in_row;
            end
            tcgr_pkg::KIND_CLEAR: begin
              cur_col_d = '0;
              cur_row_d = '0;
              evt_d     = tcgr_pkg::EV_CLEAR;
              state_d   = tcgr_pkg::ST_EVT;
            end
            tcgr_pkg::KIND_FONT: begin
              font_we = (32'(in_faddr) < 32'(STORE_BYTES));
            end
            default: ;
          endcase
        end
      end
      tcgr_pkg::ST_CHAR: begin
        // wait for the walker to issue its last read
        if (!pix.busy) begin
          state_d = scroll_q ? tcgr_pkg::ST_EVT : tcgr_pkg::ST_IDLE;
        end
      end
      tcgr_pkg::ST_EVT: begin
        if (evt_to_out) begin
          state_d = tcgr_pkg::ST_IDLE;
        end
      end
      default: state_d = tcgr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tcgr_pkg::ST_IDLE;
      cur_col_q <= '0;
      cur_row_q <= '0;
      scroll_q  <= 1'b0;
      evt_q     <= tcgr_pkg::EV_SCROLL;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      scroll_q  <= scroll_d;
      evt_q     <= evt_d;
      b_valid_q <= b_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Glyph store and pixel walker
  // --------------------------------------------------------------------------
  tcgr_glyph_mem #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_glyph_mem (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (ADDR_W'(in_faddr)),
    .wdata_i (in_fbyte),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tcgr_raster #(
    .GLYPH_W     (GLYPH_W),
    .GLYPH_H     (GLYPH_H),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_raster (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (raster_start),
    .ch_i       (in_char),
    .col_i      (cur_col_q),
    .row_i      (cur_row_q),
    .fb_width_i (fb_width_q),
    .adv_i      (issue),
    .rd_addr_o  (rd_addr),
    .pix_o      (pix)
  );

  // Stage B holds the meta of the read in flight; the memory holds its data
  always_comb begin
    if (issue) begin
      b_valid_d = 1'b1;
    end else if (b_to_out) begin
      b_valid_d = 1'b0;
    end else begin
      b_valid_d = b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_oob_q  <= pix.oob;
      b_sel_q  <= pix.bit_sel;
      b_idx_q  <= pix.pix_index;
      // the final pixel closes the item unless a scroll follows
      b_last_q <= pix.last && !scroll_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  assign b_bit  = !b_oob_q && rd_data[b_sel_q];
  assign extent = IDX_W'(fb_width_q) * IDX_W'(fb_height_q);

  always_comb begin
    if (b_to_out || evt_to_out) begin
      o_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      o_valid_d = 1'b0;
    end else begin
      o_valid_d = o_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_to_out) begin
      o_ev_q    <= tcgr_pkg::EV_PIXEL;
      o_idx_q   <= b_idx_q;
      o_color_q <= b_bit ? fg_color_q : bg_color_q;
      o_last_q  <= b_last_q;
    end else if (evt_to_out) begin
      o_ev_q    <= evt_q;
      o_idx_q   <= extent;
      o_color_q <= bg_color_q;
      o_last_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_color_q, o_idx_q};
  assign m_axis_tuser  = o_ev_q;
  assign m_axis_tlast  = o_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A read result waiting on a stalled output must not be lost
  a_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !out_free) |=> b_valid_q)
    else $error("stage B dropped a pixel under back-pressure");

  // Events are only emitted once the walker has finished its cell
  a_evt_after_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcgr_pkg::ST_EVT) |-> !pix.busy)
    else $error("event pending while the pixel walker is busy");

  // An accepted printable character starts the walker
  a_char_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_kind == tcgr_pkg::KIND_CHAR && enable_q &&
     in_char != tcgr_pkg::CHAR_CR && in_char != tcgr_pkg::CHAR_LF) |=> pix.busy)
    else $error("printable character did not start the pixel walker");

endmodule

// File: rtl/tcgr_glyph_mem.sv
// ----------------------------------------------------------------------------
// tcgr_glyph_mem
// Byte-wide glyph store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcgr_glyph_mem #(
  parameter int unsigned DEPTH  = 1920,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcgr_raster.sv
// ----------------------------------------------------------------------------
// tcgr_raster
// Walks the pixels of one glyph cell: glyph bit address and pixel index.
// ----------------------------------------------------------------------------
module tcgr_raster #(
  parameter int unsigned GLYPH_W     = 6,
  parameter int unsigned GLYPH_H     = 10,
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [tcgr_pkg::CHAR_W-1:0]           ch_i,
  input  logic [tcgr_pkg::CUR_W-1:0]            col_i,
  input  logic [tcgr_pkg::CUR_W-1:0]            row_i,
  input  logic [tcgr_pkg::FB_W-1:0]             fb_width_i,
  input  logic                                  adv_i,
  output logic [((((GLYPH_COUNT*GLYPH_W*GLYPH_H)+7)/8) > 1 ?
                 $clog2(((GLYPH_COUNT*GLYPH_W*GLYPH_H)+7)/8) : 1)-1:0] rd_addr_o,
  output tcgr_pkg::raster_pix_t                 pix_o
);

  localparam int unsigned WH          = GLYPH_W * GLYPH_H;
  localparam int unsigned BIT_W       = $clog2(256 * WH);
  localparam int unsigned BYTE_W      = BIT_W - 3;
  localparam int unsigned STORE_BYTES = (GLYPH_COUNT * WH + 7) / 8;
  localparam int unsigned ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned SX_W        = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
  localparam int unsigned SY_W        = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
  localparam int unsigned BY_W        = tcgr_pkg::CUR_W + $clog2(GLYPH_H);
  localparam int unsigned BX_W        = tcgr_pkg::CUR_W + $clog2(GLYPH_W);
  localparam int unsigned PROD_W      = BY_W + tcgr_pkg::FB_W;
  localparam int unsigned IDX_W       = tcgr_pkg::IDX_W;

  tcgr_pkg::raster_phase_e phase_q, phase_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [SX_W-1:0]   sx_q, sx_d;
  logic [SY_W-1:0]   sy_q, sy_d;
  logic [BY_W-1:0]   by_q, by_d;
  logic [BX_W-1:0]   bx_q, bx_d;
  logic [IDX_W-1:0]  line_q, line_d;
  logic [IDX_W-1:0]  pix_q, pix_d;

  logic [PROD_W-1:0] by_ext, fbw_ext, base_prod;
  logic [IDX_W-1:0]  base_idx, next_line;
  logic [BYTE_W-1:0] byte_addr;
  logic              row_end, cell_end;

  assign by_ext    = PROD_W'(by_q);
  assign fbw_ext   = PROD_W'(fb_width_i);
  assign base_prod = by_ext * fbw_ext;
  assign base_idx  = IDX_W'(base_prod) + IDX_W'(bx_q);
  assign next_line = line_q + IDX_W'(fb_width_i);

  assign byte_addr = bit_q[BIT_W-1:3];
  assign row_end   = (sx_q == SX_W'(GLYPH_W - 1));
  assign cell_end  = row_end && (sy_q == SY_W'(GLYPH_H - 1));

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    by_d    = by_q;
    bx_d    = bx_q;
    line_d  = line_q;
    pix_d   = pix_q;
    case (phase_q)
      tcgr_pkg::RS_IDLE: begin
        if (start_i) begin
          by_d    = BY_W'(row_i * GLYPH_H);
          bx_d    = BX_W'(col_i * GLYPH_W);
          bit_d   = BIT_W'(ch_i * WH);
          sx_d    = '0;
          sy_d    = '0;
          phase_d = tcgr_pkg::RS_BASE;
        end
      end
      tcgr_pkg::RS_BASE: begin
        line_d  = base_idx;
        pix_d   = base_idx;
        phase_d = tcgr_pkg::RS_RUN;
      end
      tcgr_pkg::RS_RUN: begin
        if (adv_i) begin
          bit_d = bit_q + BIT_W'(1);
          if (row_end) begin
            // next glyph line: step down one framebuffer row
            sx_d   = '0;
            sy_d   = sy_q + SY_W'(1);
            line_d = next_line;
            pix_d  = next_line;
          end else begin
            sx_d  = sx_q + SX_W'(1);
            pix_d = pix_q + IDX_W'(1);
          end
          if (cell_end) begin
            phase_d = tcgr_pkg::RS_IDLE;
          end
        end
      end
      default: phase_d = tcgr_pkg::RS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tcgr_pkg::RS_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    by_q   <= by_d;
    bx_q   <= bx_d;
    line_q <= line_d;
    pix_q  <= pix_d;
  end

  assign rd_addr_o       = ADDR_W'(byte_addr);
  assign pix_o.busy      = (phase_q != tcgr_pkg::RS_IDLE);
  assign pix_o.valid     = (phase_q == tcgr_pkg::RS_RUN);
  assign pix_o.last      = cell_end;
  assign pix_o.oob       = (32'(byte_addr) >= 32'(STORE_BYTES));
  assign pix_o.bit_sel   = bit_q[2:0];
  assign pix_o.pix_index = pix_q;

endmodule
